FILE: sv/lcdtw_pkg.sv
package lcdtw_pkg;

    // field widths
    localparam int TYPE_W   = 2;
    localparam int ID_W     = 3;
    localparam int CMD_W    = 9;
    localparam int ADDR_W   = 6;
    localparam int WORD_W   = 32;
    localparam int NIB_W    = 4;
    localparam int REP_W    = 4;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_REPEAT = 13;

    // header shifter holds ID + command word; write headers are padded low
    localparam int HDR_W      = ID_W + CMD_W;
    localparam int HDR_PAD_W  = HDR_W - ID_W - ADDR_W;
    localparam int HDR_CNT_W  = $clog2(HDR_W + 1);
    localparam int DAT_CNT_W  = $clog2(WORD_W + 1);

    // request types
    localparam logic [TYPE_W-1:0] REQ_CMD    = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_SINGLE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_REPEAT = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_LONG   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_ID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ID   = 1'd1;

    localparam logic [ID_W-1:0] COMMAND_ID_RST = 3'd4;
    localparam logic [ID_W-1:0] WRITE_ID_RST   = 3'd5;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [CMD_W-1:0]  command_word;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] payload;
        logic [REP_W-1:0]  repeat_count;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0] command_id;
        logic [ID_W-1:0] write_id;
    } t_cfg;

    typedef struct packed {
        logic vld;
        logic serial_bit;
        logic frame_end;
    } t_bit;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_HDR  = 3'b010,
        S_DAT  = 3'b100
    } t_state;

endpackage

FILE: sv/lcdtw_if.sv
interface lcdtw_req_if;
    import lcdtw_pkg::*;
    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [CMD_W-1:0]  command_word;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] payload;
    logic [REP_W-1:0]  repeat_count;

    modport source (output valid, req_type, command_word, address, payload, repeat_count,
                    input ready);
    modport sink   (input valid, req_type, command_word, address, payload, repeat_count,
                    output ready);
endinterface

interface lcdtw_bit_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic frame_end;

    modport source (output valid, serial_bit, frame_end, input ready);
    modport sink   (input valid, serial_bit, frame_end, output ready);
endinterface

interface lcdtw_cfg_if;
    import lcdtw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ID_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/lcdtw_cfg_regs.sv
module lcdtw_cfg_regs
    import lcdtw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcdtw_cfg_if.sink   i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.command_id <= COMMAND_ID_RST;
            r_cfg.write_id   <= WRITE_ID_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_COMMAND_ID: r_cfg.command_id <= i_cfg.data;
                CFG_WRITE_ID:   r_cfg.write_id   <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

FILE: sv/lcdtw_shifter.sv
module lcdtw_shifter
    import lcdtw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_load,
    input  t_req i_req,
    input  logic i_take,
    output logic o_ready,
    output t_bit o_bit
);

    t_state                r_state, n_state;
    logic [HDR_W-1:0]      r_hdr, n_hdr;
    logic [HDR_CNT_W-1:0]  r_hdr_cnt, n_hdr_cnt;
    logic [WORD_W-1:0]     r_word, n_word;
    logic [DAT_CNT_W-1:0]  r_dat_cnt, n_dat_cnt;
    logic [NIB_W-1:0]      r_nib, n_nib;
    logic [REP_W-1:0]      r_rep, n_rep;
    logic                  step;
    logic                  last;
    logic [REP_W-1:0]      rep_sat;

    assign rep_sat = (i_req.repeat_count > REP_W'(MAX_REPEAT)) ?
                     REP_W'(MAX_REPEAT) : i_req.repeat_count;

    always_comb begin
        n_state   = r_state;
        n_hdr     = r_hdr;
        n_hdr_cnt = r_hdr_cnt;
        n_word    = r_word;
        n_dat_cnt = r_dat_cnt;
        n_nib     = r_nib;
        n_rep     = r_rep;
        step      = i_take && (r_state != S_IDLE);
        o_bit.vld = step;

        unique case (r_state)
            S_HDR: begin
                o_bit.serial_bit = r_hdr[HDR_W-1];
                last = (r_hdr_cnt == HDR_CNT_W'(1)) && (r_rep == '0);
            end
            S_DAT: begin
                o_bit.serial_bit = r_word[WORD_W-1];
                last = (r_dat_cnt == DAT_CNT_W'(1)) && (r_rep == REP_W'(1));
            end
            default: begin
                o_bit.serial_bit = 1'b0;
                last = 1'b0;
            end
        endcase
        o_bit.frame_end = last;

        if (step) begin
            unique case (r_state)
                S_HDR: begin
                    n_hdr     = {r_hdr[HDR_W-2:0], 1'b0};
                    n_hdr_cnt = r_hdr_cnt - HDR_CNT_W'(1);
                    if (r_hdr_cnt == HDR_CNT_W'(1)) begin
                        n_state = (r_rep == '0) ? S_IDLE : S_DAT;
                    end
                end
                S_DAT: begin
                    n_word    = {r_word[WORD_W-2:0], 1'b0};
                    n_dat_cnt = r_dat_cnt - DAT_CNT_W'(1);
                    if (r_dat_cnt == DAT_CNT_W'(1)) begin
                        if (r_rep == REP_W'(1)) begin
                            n_state = S_IDLE;
                        end else begin
                            // next copy of the nibble
                            n_rep     = r_rep - REP_W'(1);
                            n_word    = {r_nib, {(WORD_W-NIB_W){1'b0}}};
                            n_dat_cnt = DAT_CNT_W'(NIB_W);
                        end
                    end
                end
                default: ;
            endcase
        end

        if (i_load) begin
            n_state = S_HDR;
            n_nib   = i_req.payload[NIB_W-1:0];
            if (i_req.req_type == REQ_CMD) begin
                n_hdr     = {i_cfg.command_id, i_req.command_word};
                n_hdr_cnt = HDR_CNT_W'(HDR_W);
            end else begin
                n_hdr     = {i_cfg.write_id, i_req.address, {HDR_PAD_W{1'b0}}};
                n_hdr_cnt = HDR_CNT_W'(ID_W + ADDR_W);
            end
            if (i_req.req_type == REQ_LONG) begin
                n_word    = i_req.payload;
                n_dat_cnt = DAT_CNT_W'(WORD_W);
            end else begin
                n_word    = {i_req.payload[NIB_W-1:0], {(WORD_W-NIB_W){1'b0}}};
                n_dat_cnt = DAT_CNT_W'(NIB_W);
            end
            unique case (i_req.req_type)
                REQ_CMD:    n_rep = '0;
                REQ_SINGLE: n_rep = REP_W'(1);
                REQ_REPEAT: n_rep = rep_sat;
                REQ_LONG:   n_rep = REP_W'(1);
                default:    n_rep = '0;
            endcase
        end
    end

    // next request may load on the cycle the final bit leaves
    assign o_ready = (r_state == S_IDLE) || (step && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr     <= n_hdr;
        r_hdr_cnt <= n_hdr_cnt;
        r_word    <= n_word;
        r_dat_cnt <= n_dat_cnt;
        r_nib     <= n_nib;
        r_rep     <= n_rep;
    end

endmodule

FILE: sv/lcd_three_wire_frame_sender.sv
// Three-wire LCD segment controller frame sender.
//
// i_req  : frame requests (type, command word, address, payload, repeat count).
// o_bits : one item per serial bit, MSB first; frame_end marks the last bit of
//          a frame, where chip select is to be released.
// i_cfg  : register writes; index 0 command ID, index 1 write ID. Always ready.
//          Write only while no frame is in flight.
//
// Frame lengths: command 12 bits, single write 13, repeated write 9 + 4 * n
// (n saturated at 13, so up to 61), long write 41.
// The first bit passes through the shifter's header register and then the
// output register before it is presented. Bits leave the header/data shift
// registers one bit per cycle while the receiver does not stall; the next
// request is taken on the cycle the final bit moves into the output register.
// Reset (synchronous, active low): shifter idles, output empties, IDs return
// to 4 (command) and 5 (write).
// Receiver stall: the output register holds its bit and the shifter freezes;
// nothing is dropped.
module lcd_three_wire_frame_sender
    import lcdtw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    lcdtw_req_if.sink    i_req,
    lcdtw_bit_if.source  o_bits,
    lcdtw_cfg_if.sink    i_cfg
);

    t_cfg cfg;
    t_req req;
    t_bit shift_bit;
    logic load;
    logic slot_free;
    logic shift_ready;

    logic r_out_vld;
    logic r_out_bit;
    logic r_out_end;

    // register file for the two frame IDs
    lcdtw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign req.req_type     = i_req.req_type;
    assign req.command_word = i_req.command_word;
    assign req.address      = i_req.address;
    assign req.payload      = i_req.payload;
    assign req.repeat_count = i_req.repeat_count;

    assign i_req.ready = shift_ready;
    assign load        = i_req.valid && shift_ready;

    // output stage free when empty or being drained this cycle
    assign slot_free = !r_out_vld || o_bits.ready;

    lcdtw_shifter u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_load  (load),
        .i_req   (req),
        .i_take  (slot_free),
        .o_ready (shift_ready),
        .o_bit   (shift_bit)
    );

    // output register between shifter and receiver; the receiver's ready still reaches the shifter via slot_free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (slot_free) begin
            r_out_vld <= shift_bit.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            r_out_bit <= shift_bit.serial_bit;
            r_out_end <= shift_bit.frame_end;
        end
    end

    assign o_bits.valid      = r_out_vld;
    assign o_bits.serial_bit = r_out_bit;
    assign o_bits.frame_end  = r_out_end;

endmodule
